FILE: hw/rtl/wrm_pkg.sv
// shared types and constants of the windowed event rate meter
package wrm_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned QUO_W    = 32;
    localparam int unsigned ACC_W    = 33;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned STEP_W   = 5;

    localparam logic [DATA_W-1:0] CNT_MAX           = 32'hFFFF_FFFF;
    localparam logic [QUO_W-1:0]  RATE_SAT          = 32'hFFFF_FFFF;
    localparam logic [ACC_W-1:0]  ACC_MAX           = 33'h1_FFFF_FFFF;
    localparam logic [DATA_W-1:0] UPDATE_PERIOD_RST = 32'd6554;
    localparam logic [STEP_W-1:0] LAST_STEP         = 5'd31;

    // register index, taken from paddr word bit
    localparam logic REG_UPDATE_PERIOD = 1'b0;

    // item kinds on s_tuser
    localparam logic FUNC_EVENT = 1'b0;
    localparam logic FUNC_CLOSE = 1'b1;

    // one ring entry
    typedef struct packed {
        logic [DATA_W-1:0] dur;
        logic [DATA_W-1:0] cnt;
    } slot_word_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
    } div_status_t;

endpackage

FILE: hw/rtl/windowed_event_rate_meter.sv
// event rate meter over a ring of slots: an item passes the read, modify and finish states, then the output hand-off
// a close item that reaches the update period also sums all slots and divides the sums to recompute the rate;
// the division is skipped when the quotient saturates
// (slot summing reads the ring memory once per cycle, the divider makes one bit per cycle)
// one item at a time: s_tready is high only while the sequencer is idle
// rst_n is asynchronous, active low; slot valid bits clear at once, no clearing pass
module windowed_event_rate_meter #(
    parameter int unsigned SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // stream input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] slot_duration
    input  logic [0:0]  s_tuser,   // [0] func
    // stream output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] rate, [63:32] total_events
    output logic [1:0]  m_tuser,   // [0] rate_updated, [1] zero_window
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wrm_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int unsigned PTR_W = $clog2(SLOTS);
    localparam int unsigned SUM_W = wrm_pkg::DATA_W + $clog2(SLOTS);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_MOD,
        ST_SUM,
        ST_SUM_END,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    state_t                       state_reg;
    logic                         func_reg;
    logic [wrm_pkg::DATA_W-1:0]   dur_reg;
    logic [PTR_W-1:0]             ptr_reg;
    logic [PTR_W-1:0]             idx_reg;
    logic                         sum_pipe_reg;
    logic [SUM_W-1:0]             sc_reg;
    logic [SUM_W-1:0]             sd_reg;
    logic [wrm_pkg::ACC_W-1:0]    acc_reg;
    logic [wrm_pkg::QUO_W-1:0]    rate_reg;
    logic [wrm_pkg::DATA_W-1:0]   total_reg;
    logic [wrm_pkg::DATA_W-1:0]   period_reg;
    logic                         upd_reg;
    logic                         zero_reg;
    logic                         out_vld_reg;
    logic [63:0]                  out_data_reg;
    logic [1:0]                   out_user_reg;

    wrm_pkg::slot_word_t          rd_data;
    wrm_pkg::slot_word_t          wr_data;
    logic                         rd_en;
    logic [PTR_W-1:0]             rd_addr;
    logic                         wr_en;
    logic                         clr_en;
    logic [PTR_W-1:0]             ptr_next;
    logic                         out_free;

    logic [wrm_pkg::ACC_W:0]      acc_sum;
    logic [wrm_pkg::ACC_W-1:0]    acc_sat;
    logic                         acc_hit;
    logic [wrm_pkg::DATA_W-1:0]   cnt_inc;

    logic                         div_start;
    logic [wrm_pkg::QUO_W-1:0]    div_quo;
    wrm_pkg::div_status_t         div_st;

    // handshake and ring control
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_vld_reg || m_tready;
    assign ptr_next = (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + 1'b1;
    assign rd_en    = (state_reg == ST_RD) || (state_reg == ST_SUM);
    assign rd_addr  = (state_reg == ST_SUM) ? idx_reg : ptr_reg;
    assign wr_en    = (state_reg == ST_MOD);
    assign clr_en   = (state_reg == ST_FINISH) && out_free && (func_reg == wrm_pkg::FUNC_CLOSE);
    assign div_start = (state_reg == ST_DIV_START);

    // saturating slot count and period accumulator
    assign cnt_inc = (rd_data.cnt == wrm_pkg::CNT_MAX) ? rd_data.cnt : rd_data.cnt + 1'b1;
    assign acc_sum = {1'b0, acc_reg} + {2'b00, dur_reg};
    assign acc_sat = acc_sum[wrm_pkg::ACC_W] ? wrm_pkg::ACC_MAX : acc_sum[wrm_pkg::ACC_W-1:0];
    assign acc_hit = acc_sat >= {1'b0, period_reg};

    // write-back word of the current slot
    always_comb
    begin
        if (func_reg == wrm_pkg::FUNC_EVENT)
        begin
            wr_data.dur = rd_data.dur;
            wr_data.cnt = cnt_inc;
        end
        else
        begin
            wr_data.dur = dur_reg;
            wr_data.cnt = rd_data.cnt;
        end
    end

    wrm_slot_mem #(
        .SLOTS (SLOTS),
        .PTR_W (PTR_W)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (ptr_reg),
        .wr_data  (wr_data),
        .clr_en   (clr_en),
        .clr_addr (ptr_next)
    );

    wrm_divider #(
        .SUM_W (SUM_W)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .cnt    (sc_reg),
        .dur    (sd_reg),
        .quo    (div_quo),
        .status (div_st)
    );

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == wrm_pkg::REG_UPDATE_PERIOD) ? period_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= wrm_pkg::UPDATE_PERIOD_RST;
        end
        else if (psel && penable && pwrite && pready
                 && paddr[2] == wrm_pkg::REG_UPDATE_PERIOD)
        begin
            period_reg <= pwdata;
        end
    end

    // slot summing, one memory read per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_pipe_reg <= 1'b0;
        end
        else
        begin
            sum_pipe_reg <= (state_reg == ST_SUM);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MOD)
        begin
            sc_reg <= '0;
            sd_reg <= '0;
        end
        else if (sum_pipe_reg)
        begin
            sc_reg <= sc_reg + SUM_W'(rd_data.cnt);
            sd_reg <= sd_reg + SUM_W'(rd_data.dur);
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            func_reg    <= wrm_pkg::FUNC_EVENT;
            ptr_reg     <= '0;
            idx_reg     <= '0;
            acc_reg     <= '0;
            rate_reg    <= '0;
            total_reg   <= '0;
            upd_reg     <= 1'b0;
            zero_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (out_vld_reg && m_tready && state_reg != ST_FINISH)
            begin
                out_vld_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        func_reg  <= s_tuser[0];
                        dur_reg   <= s_tdata;
                        upd_reg   <= 1'b0;
                        zero_reg  <= 1'b0;
                        state_reg <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_MOD;
                end
                ST_MOD:
                begin
                    if (func_reg == wrm_pkg::FUNC_EVENT)
                    begin
                        if (total_reg != wrm_pkg::CNT_MAX)
                        begin
                            total_reg <= total_reg + 1'b1;
                        end
                        state_reg <= ST_FINISH;
                    end
                    else if (acc_hit)
                    begin
                        acc_reg   <= acc_sat - {1'b0, period_reg};
                        upd_reg   <= 1'b1;
                        idx_reg   <= '0;
                        state_reg <= ST_SUM;
                    end
                    else
                    begin
                        acc_reg   <= acc_sat;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_SUM:
                begin
                    if (idx_reg == LAST_SLOT)
                    begin
                        state_reg <= ST_SUM_END;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_SUM_END:
                begin
                    state_reg <= ST_DIV_START;
                end
                ST_DIV_START:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_st.done)
                    begin
                        rate_reg  <= div_quo;
                        zero_reg  <= div_st.zero;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_vld_reg  <= 1'b1;
                        out_data_reg <= {total_reg, rate_reg};
                        out_user_reg <= {zero_reg, upd_reg};
                        if (func_reg == wrm_pkg::FUNC_CLOSE)
                        begin
                            ptr_reg <= ptr_next;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // checks
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished outside its wait state");

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while the previous one is in work");

    a_zero_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tuser[1] || m_tuser[0])
        else $error("zero window flagged without a recompute");

    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_st.busy)
        else $error("divider started while busy");

endmodule

FILE: hw/rtl/wrm_slot_mem.sv
// ring memory of slot counts and durations with per-entry valid bits
module wrm_slot_mem #(
    parameter int unsigned SLOTS = 16,
    parameter int unsigned PTR_W = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [PTR_W-1:0]    rd_addr,
    output wrm_pkg::slot_word_t rd_data,
    input  logic                wr_en,
    input  logic [PTR_W-1:0]    wr_addr,
    input  wrm_pkg::slot_word_t wr_data,
    input  logic                clr_en,
    input  logic [PTR_W-1:0]    clr_addr
);

    wrm_pkg::slot_word_t mem [SLOTS];
    logic [SLOTS-1:0]    vld_reg;
    wrm_pkg::slot_word_t rd_word_reg;
    logic                rd_vld_reg;

    // storage write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // valid bits: set on write, dropped when a slot is opened again
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (clr_en)
            begin
                vld_reg[clr_addr] <= 1'b0;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // entries never written since clearing read as zero
    assign rd_data = rd_vld_reg ? rd_word_reg : '0;

endmodule

FILE: hw/rtl/wrm_divider.sv
// restoring divider, one quotient bit per cycle, saturating
module wrm_divider #(
    parameter int unsigned SUM_W = 36
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [SUM_W-1:0]              cnt,
    input  logic [SUM_W-1:0]              dur,
    output logic [wrm_pkg::QUO_W-1:0]     quo,
    output wrm_pkg::div_status_t          status
);

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_DONE
    } dv_state_t;

    dv_state_t                     state_reg;
    logic [SUM_W-1:0]              rem_reg;
    logic [SUM_W-1:0]              dur_reg;
    logic [wrm_pkg::QUO_W-1:0]     quo_reg;
    logic [wrm_pkg::STEP_W-1:0]    step_reg;
    logic                          zero_reg;

    logic [SUM_W:0] shifted;
    logic [SUM_W:0] diff;
    logic           fits;

    // one trial subtraction
    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, dur_reg};
    assign fits    = shifted >= {1'b0, dur_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            step_reg  <= '0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                DV_IDLE:
                begin
                    if (start)
                    begin
                        dur_reg  <= dur;
                        rem_reg  <= cnt;
                        step_reg <= '0;
                        zero_reg <= (dur == '0);
                        if (dur == '0 || cnt >= dur)
                        begin
                            quo_reg   <= wrm_pkg::RATE_SAT;
                            state_reg <= DV_DONE;
                        end
                        else
                        begin
                            quo_reg   <= '0;
                            state_reg <= DV_RUN;
                        end
                    end
                end
                DV_RUN:
                begin
                    quo_reg <= {quo_reg[wrm_pkg::QUO_W-2:0], fits};
                    if (fits)
                    begin
                        rem_reg <= diff[SUM_W-1:0];
                    end
                    else
                    begin
                        rem_reg <= shifted[SUM_W-1:0];
                    end
                    if (step_reg == wrm_pkg::LAST_STEP)
                    begin
                        state_reg <= DV_DONE;
                    end
                    step_reg <= step_reg + 1'b1;
                end
                DV_DONE:
                begin
                    state_reg <= DV_IDLE;
                end
                default:
                begin
                    state_reg <= DV_IDLE;
                end
            endcase
        end
    end

    assign quo         = quo_reg;
    assign status.busy = (state_reg != DV_IDLE);
    assign status.done = (state_reg == DV_DONE);
    assign status.zero = zero_reg;

endmodule
